// ===== rtl/core/mstb_pkg.sv =====
// ----------------------------------------------------------------------------
// mstb_pkg
// Shared constants, types and helpers for the step-tone generator bank.
// ----------------------------------------------------------------------------
package mstb_pkg;

   localparam int CHANNELS   = 16;
   localparam int COUNT_BITS = 16;
   localparam int POS_BITS   = 16;
   localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // request command codes
   localparam logic CMD_TICK = 1'b0;
   localparam logic CMD_SET  = 1'b1;

   // csr register indexes
   localparam logic CSR_UPPER_LIMIT = 1'b0;
   localparam logic CSR_LOWER_LIMIT = 1'b1;

   localparam logic [POS_BITS-1:0] UPPER_LIMIT_RST = POS_BITS'(80);
   localparam logic [POS_BITS-1:0] LOWER_LIMIT_RST = '0;

   localparam logic [47:0] CNT_MAX_W = (48'd1 << COUNT_BITS) - 48'd1;

   // one memory entry per channel
   typedef struct packed {
      logic [COUNT_BITS-1:0] period;
      logic [COUNT_BITS-1:0] count;
      logic [POS_BITS-1:0]   pos;
   } entry_type;

   // result of updating one channel on a tick
   typedef struct packed {
      entry_type ent;
      logic      toggle;
      logic      dir_flip;
   } upd_type;

   // clamp a requested period to the count range
   function automatic logic [COUNT_BITS-1:0] sat_period(input logic [15:0] p);
      logic [47:0] wide;
      wide = 48'(p);
      if (wide > CNT_MAX_W) begin
         return '1;
      end
      return COUNT_BITS'(wide);
   endfunction

endpackage

// ===== rtl/core/mstb_if.sv =====
// ----------------------------------------------------------------------------
// mstb request / response interfaces
// Valid-ready channels carrying the command request and the pin response.
// ----------------------------------------------------------------------------
interface mstb_req_if;
   logic        valid;
   logic        ready;
   logic        cmd;
   logic [3:0]  channel;
   logic [15:0] period;
   logic        any_note_active;

   modport source (output valid, cmd, channel, period, any_note_active, input ready);
   modport sink   (input valid, cmd, channel, period, any_note_active, output ready);
endinterface

interface mstb_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] step_levels;
   logic [15:0] direction_levels;
   logic [15:0] toggled_mask;

   modport source (output valid, step_levels, direction_levels, toggled_mask, input ready);
   modport sink   (input valid, step_levels, direction_levels, toggled_mask, output ready);
endinterface

// ===== rtl/core/multichannel_step_tone_with_bounce.sv =====
// ----------------------------------------------------------------------------
// multichannel_step_tone_with_bounce
// Bank of stepper tone generators: per-channel period, count and head position
// held in one RAM, walked one channel per cycle on each tick with a note active.
// ----------------------------------------------------------------------------
// Flow: a tick request walks all channels in ST_TICK before ST_DONE; a set
//   request passes ST_SET, and an idle tick (no note active) goes to ST_DONE.
// Throughput: one request at a time; a tick is bounded by the single RAM read
//   port walking one channel entry per cycle.
// Reset (synchronous, active high): all channels silent, counts, positions,
//   step and direction pins zero, upper limit 80, lower limit 0, no response.
module multichannel_step_tone_with_bounce (
   input  logic                          clock,
   input  logic                          reset,
   mstb_req_if.sink                      req,
   mstb_rsp_if.source                    rsp,
   input  logic                          csr_wr_en,
   input  logic                          csr_idx,
   input  logic [mstb_pkg::POS_BITS-1:0] csr_wdata
);
   import mstb_pkg::*;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a request
   localparam logic [1:0] ST_SET  = 2'd1;  // read-modify-write of one period
   localparam logic [1:0] ST_TICK = 2'd2;  // walking channels
   localparam logic [1:0] ST_DONE = 2'd3;  // handing the response over

   localparam logic [CH_BITS-1:0] LAST_CH = CH_BITS'(CHANNELS - 1);

   logic [1:0]            state_ff,  state_in;
   logic [CH_BITS-1:0]    idx_ff,    idx_in;
   logic [CH_BITS-1:0]    chan_ff,   chan_in;
   logic [COUNT_BITS-1:0] per_ff,    per_in;
   logic [CHANNELS-1:0]   vld_ff,    vld_in;    // entry written since reset
   logic                  rd_vld_ff, rd_vld_in; // valid bit of the entry being read
   logic [CHANNELS-1:0]   step_ff,   step_in;
   logic [CHANNELS-1:0]   dir_ff,    dir_in;
   logic [CHANNELS-1:0]   tog_ff,    tog_in;
   logic [POS_BITS-1:0]   hi_ff,     hi_in;
   logic [POS_BITS-1:0]   lo_ff,     lo_in;
   logic                  rsp_vld_ff, rsp_vld_in;
   logic [15:0]           out_step_ff, out_step_in;
   logic [15:0]           out_dir_ff,  out_dir_in;
   logic [15:0]           out_tog_ff,  out_tog_in;

   logic                  ram_rd_en;
   logic [CH_BITS-1:0]    ram_rd_addr;
   logic                  ram_wr_en;
   logic [CH_BITS-1:0]    ram_wr_addr;
   entry_type             ram_wr_data;
   logic [$bits(entry_type)-1:0] ram_rd_data;

   entry_type             cur_ent;
   upd_type               upd;
   logic                  req_acc;
   logic                  out_free;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_acc   = req.valid && req.ready;
   assign out_free  = !rsp_vld_ff || rsp.ready;

   // never-written entries read as the reset value
   assign cur_ent = rd_vld_ff ? entry_type'(ram_rd_data) : '0;

   mstb_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (CHANNELS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mstb_chan_upd u_upd (
      .ent         (cur_ent),
      .dir         (dir_ff[idx_ff]),
      .upper_limit (hi_ff),
      .lower_limit (lo_ff),
      .upd         (upd)
   );

   // Sequencer. Each read is issued ahead of its write-back; the read of channel
   // n+1 and the write of channel n never hit the same entry, and no new
   // request is taken before the last write-back, so no forwarding is needed.
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      chan_in     = chan_ff;
      per_in      = per_ff;
      vld_in      = vld_ff;
      step_in     = step_ff;
      dir_in      = dir_ff;
      tog_in      = tog_ff;
      rsp_vld_in  = rsp_vld_ff && !rsp.ready;
      out_step_in = out_step_ff;
      out_dir_in  = out_dir_ff;
      out_tog_in  = out_tog_ff;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = upd.ent;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               tog_in = '0;
               if (req.cmd == CMD_SET) begin
                  chan_in = CH_BITS'(req.channel);
                  per_in  = sat_period(req.period);
                  if (32'(req.channel) < CHANNELS) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = CH_BITS'(req.channel);
                     state_in    = ST_SET;
                  end else begin
                     state_in = ST_DONE;   // out-of-range channel: no effect
                  end
               end else if (req.any_note_active) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  idx_in      = '0;
                  state_in    = ST_TICK;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SET: begin
            // keep count and position, replace the period
            ram_wr_en          = 1'b1;
            ram_wr_addr        = chan_ff;
            ram_wr_data        = cur_ent;
            ram_wr_data.period = per_ff;
            vld_in[chan_ff]    = 1'b1;
            state_in           = ST_DONE;
         end
         ST_TICK: begin
            ram_wr_en       = 1'b1;
            vld_in[idx_ff]  = 1'b1;
            step_in[idx_ff] = step_ff[idx_ff] ^ upd.toggle;
            dir_in[idx_ff]  = dir_ff[idx_ff] ^ upd.dir_flip;
            tog_in[idx_ff]  = upd.toggle;
            if (idx_ff == LAST_CH) begin
               state_in = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_ff + CH_BITS'(1);
               idx_in      = idx_ff + CH_BITS'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               out_step_in = 16'(step_ff);
               out_dir_in  = 16'(dir_ff);
               out_tog_in  = 16'(tog_ff);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_vld_in = ram_rd_en ? vld_ff[ram_rd_addr] : rd_vld_ff;

   // limit registers, to be written only while idle; the block does not enforce it
   always_comb begin
      hi_in = hi_ff;
      lo_in = lo_ff;
      if (csr_wr_en) begin
         case (csr_idx)
            CSR_UPPER_LIMIT: hi_in = csr_wdata;
            CSR_LOWER_LIMIT: lo_in = csr_wdata;
            default: begin
               hi_in = hi_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         step_ff    <= '0;
         dir_ff     <= '0;
         hi_ff      <= UPPER_LIMIT_RST;
         lo_ff      <= LOWER_LIMIT_RST;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         vld_ff     <= vld_in;
         rd_vld_ff  <= rd_vld_in;
         step_ff    <= step_in;
         dir_ff     <= dir_in;
         hi_ff      <= hi_in;
         lo_ff      <= lo_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      chan_ff     <= chan_in;
      per_ff      <= per_in;
      tog_ff      <= tog_in;
      out_step_ff <= out_step_in;
      out_dir_ff  <= out_dir_in;
      out_tog_ff  <= out_tog_in;
   end

   assign rsp.valid            = rsp_vld_ff;
   assign rsp.step_levels      = out_step_ff;
   assign rsp.direction_levels = out_dir_ff;
   assign rsp.toggled_mask     = out_tog_ff;

endmodule

// ===== rtl/core/mstb_ram.sv =====
// ----------------------------------------------------------------------------
// mstb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mstb_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mstb_chan_upd.sv =====
// ----------------------------------------------------------------------------
// mstb_chan_upd
// Tick update of one channel entry: count, toggle, head step and bounce.
// ----------------------------------------------------------------------------
module mstb_chan_upd (
   input  mstb_pkg::entry_type         ent,
   input  logic                        dir,
   input  logic [mstb_pkg::POS_BITS-1:0] upper_limit,
   input  logic [mstb_pkg::POS_BITS-1:0] lower_limit,
   output mstb_pkg::upd_type           upd
);
   import mstb_pkg::*;

   logic                active;
   logic                hit;
   logic [POS_BITS-1:0] pos_nxt;

   assign active  = (ent.period != '0);
   assign hit     = active && (ent.count >= ent.period);
   // dir 1 = decrementing
   assign pos_nxt = dir ? (ent.pos - POS_BITS'(1)) : (ent.pos + POS_BITS'(1));

   always_comb begin
      upd          = '0;
      upd.ent      = ent;
      if (hit) begin
         upd.ent.count = '0;
         upd.ent.pos   = pos_nxt;
         upd.toggle    = 1'b1;
         upd.dir_flip  = (pos_nxt == upper_limit) || (pos_nxt == lower_limit);
      end else if (active) begin
         upd.ent.count = ent.count + COUNT_BITS'(1);
      end
   end

endmodule

// ===== rtl/core/mstb_checker.sv =====
// ----------------------------------------------------------------------------
// mstb_checker
// Port-level checks of the step-tone generator bank, bound to the top level.
// ----------------------------------------------------------------------------
module mstb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_step_levels,
   input logic [15:0] rsp_toggled_mask
);

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one request in flight: the block goes busy after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while previous one still in work");

   // a new response only appears at the end of a busy period
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response without request work");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_step_levels) && $stable(rsp_toggled_mask)))
      else $error("stalled response changed");

endmodule

bind multichannel_step_tone_with_bounce mstb_checker u_mstb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req.valid),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_step_levels  (rsp.step_levels),
   .rsp_toggled_mask (rsp.toggled_mask)
);
